/* rtl/multi_queue_sorted_insert_engine_macros.svh */
// Assertion macros for the engine's controller.
// MQSI_ASSERT checks that a property holds.
// MQSI_ASSERT_NEVER checks that a condition never holds.
`ifndef MULTI_QUEUE_SORTED_INSERT_ENGINE_MACROS_SVH
`define MULTI_QUEUE_SORTED_INSERT_ENGINE_MACROS_SVH
`ifndef SYNTH
`define MQSI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mqsi assertion failed");
`define MQSI_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("mqsi forbidden condition seen");
`else
`define MQSI_ASSERT(lbl, clk, rstn, prop)
`define MQSI_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* rtl/mqsi_pkg.sv */
package mqsi_pkg;

  // Default sizes.
  localparam int unsigned NODES_DEF     = 32;
  localparam int unsigned QUEUES_DEF    = 16;
  localparam int unsigned KEY_BITS_DEF  = 32;
  localparam int unsigned DATA_BITS_DEF = 32;

  // Fixed field widths.
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned QID_W  = 4;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned ST_W   = 3;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ALLOC    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REM_HEAD = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_KEY  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_STATUS   = 3'd5;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [ST_W-1:0] ST_NOT_EMPTY = 3'd2;
  localparam logic [ST_W-1:0] ST_NO_QUEUES = 3'd3;
  localparam logic [ST_W-1:0] ST_POOL_FULL = 3'd4;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd5;
  localparam logic [ST_W-1:0] ST_BAD_QUEUE = 3'd6;

  // Order modes.
  localparam logic [MODE_W-1:0] MODE_SIGNED   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNSIGNED = 2'd2;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_IDLE     = 5'd0,
    OP_LOAD     = 5'd1,
    OP_SET_ST   = 5'd2,
    OP_ALLOC    = 5'd3,
    OP_POP_A    = 5'd4,
    OP_POP_B    = 5'd5,
    OP_SET_TAIL = 5'd6,
    OP_READ     = 5'd7,
    OP_ADVANCE  = 5'd8,
    OP_SET_PREV = 5'd9,
    OP_INS_A    = 5'd10,
    OP_INS_B    = 5'd11,
    OP_TAKE_KEY = 5'd12,
    OP_TAKE_PAY = 5'd13,
    OP_UNL_A    = 5'd14,
    OP_UNL_B    = 5'd15,
    OP_CUR_HEAD = 5'd16
  } dp_op_e;

  typedef struct packed {
    dp_op_e          op;
    logic [ST_W-1:0] st;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             bad;
    logic             no_queue;
    logic             pool_empty;
    logic             q_empty;
    logic             sorted;
    logic             cur_nil;
    logic             after;
    logic             key_eq;
  } dp_sts_t;

endpackage

/* rtl/mqsi_dp.sv */
module mqsi_dp #(
  parameter int unsigned NODES     = mqsi_pkg::NODES_DEF,
  parameter int unsigned QUEUES    = mqsi_pkg::QUEUES_DEF,
  parameter int unsigned KEY_BITS  = mqsi_pkg::KEY_BITS_DEF,
  parameter int unsigned DATA_BITS = mqsi_pkg::DATA_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [mqsi_pkg::CMD_W-1:0]   command_i,
  input  logic [mqsi_pkg::QID_W-1:0]   queue_id_i,
  input  logic [mqsi_pkg::MODE_W-1:0]  order_mode_i,
  input  logic [KEY_BITS-1:0]          key_i,
  input  logic [DATA_BITS-1:0]         payload_i,
  input  mqsi_pkg::dp_cmd_t            dp_cmd_i,
  output mqsi_pkg::dp_sts_t            dp_sts_o,
  output logic [mqsi_pkg::ST_W-1:0]    status_o,
  output logic [mqsi_pkg::QID_W-1:0]   queue_out_o,
  output logic [KEY_BITS-1:0]          key_out_o,
  output logic [DATA_BITS-1:0]         payload_out_o
);

  localparam int unsigned AW  = $clog2(NODES);
  localparam int unsigned PW  = AW + 1;
  localparam int unsigned QIW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int unsigned QCW = $clog2(QUEUES + 1);
  localparam logic [PW-1:0] NIL = PW'(NODES);

  // Latched command fields.
  logic [mqsi_pkg::CMD_W-1:0]  cmd_q;
  logic [mqsi_pkg::QID_W-1:0]  qid_q;
  logic [mqsi_pkg::MODE_W-1:0] mode_q;
  logic [KEY_BITS-1:0]         key_q;
  logic [DATA_BITS-1:0]        pay_q;

  // Queue tables and pool bookkeeping.
  logic [PW-1:0]               head_q  [QUEUES];
  logic [PW-1:0]               tail_q  [QUEUES];
  logic [mqsi_pkg::MODE_W-1:0] order_q [QUEUES];
  logic [QUEUES-1:0]           in_use_q;
  logic [QCW-1:0]              qcnt_q;
  logic [PW-1:0]               free_head_q;
  logic [PW-1:0]               fresh_q;

  // Walk pointers and entry read data.
  logic [PW-1:0]        cur_q, n_q, p_q;
  logic [KEY_BITS-1:0]  rk_q;
  logic [DATA_BITS-1:0] rp_q;
  logic [PW-1:0]        rn_q, rv_q;

  // Result registers.
  logic [mqsi_pkg::ST_W-1:0]  st_q;
  logic [mqsi_pkg::QID_W-1:0] qout_q;
  logic [KEY_BITS-1:0]        kout_q;
  logic [DATA_BITS-1:0]       pout_q;

  // Entry storage.
  logic [KEY_BITS-1:0]  mem_key  [NODES];
  logic [DATA_BITS-1:0] mem_pay  [NODES];
  logic [PW-1:0]        mem_next [NODES];
  logic [PW-1:0]        mem_prev [NODES];

  logic [QIW-1:0] q_idx;
  logic [QCW-1:0] alloc_num;
  logic [QIW-1:0] alloc_idx;
  logic           rd_en;
  logic [AW-1:0]  rd_a;
  logic           next_we, prev_we;
  logic [PW-1:0]  next_wa, next_wd, prev_wa, prev_wd;
  logic [KEY_BITS-1:0] cmp_a, cmp_b;

  assign q_idx     = QIW'(qid_q);
  assign alloc_num = qcnt_q - QCW'(1);
  assign alloc_idx = QIW'(alloc_num);

  // Status back to the controller.
  always_comb begin
    cmp_a = rk_q;
    cmp_b = key_q;
    if (order_q[q_idx] == mqsi_pkg::MODE_SIGNED) begin
      cmp_a[KEY_BITS-1] = ~rk_q[KEY_BITS-1];
      cmp_b[KEY_BITS-1] = ~key_q[KEY_BITS-1];
    end
    dp_sts_o.cmd        = cmd_q;
    dp_sts_o.bad        = (cmd_q > mqsi_pkg::CMD_STATUS) ||
                          (32'(qid_q) >= 32'(QUEUES)) || !in_use_q[q_idx];
    dp_sts_o.no_queue   = (qcnt_q == '0);
    dp_sts_o.pool_empty = (free_head_q == NIL);
    dp_sts_o.q_empty    = (head_q[q_idx] == NIL);
    dp_sts_o.sorted     = (order_q[q_idx] == mqsi_pkg::MODE_SIGNED) ||
                          (order_q[q_idx] == mqsi_pkg::MODE_UNSIGNED);
    dp_sts_o.cur_nil    = (cur_q == NIL);
    dp_sts_o.after      = (cmp_a > cmp_b);
    dp_sts_o.key_eq     = (rk_q == key_q);
  end

  // Entry read port address.
  always_comb begin
    rd_en = 1'b0;
    rd_a  = cur_q[AW-1:0];
    if (dp_cmd_i.op == mqsi_pkg::OP_READ) begin
      rd_en = 1'b1;
    end else if (dp_cmd_i.op == mqsi_pkg::OP_POP_A) begin
      rd_en = 1'b1;
      rd_a  = free_head_q[AW-1:0];
    end
  end

  // Link write ports, one write per array per cycle.
  always_comb begin
    next_we = 1'b0;
    next_wa = n_q;
    next_wd = cur_q;
    prev_we = 1'b0;
    prev_wa = n_q;
    prev_wd = p_q;
    case (dp_cmd_i.op)
      mqsi_pkg::OP_INS_A: begin
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      mqsi_pkg::OP_INS_B: begin
        next_we = (p_q != NIL);
        next_wa = p_q;
        next_wd = n_q;
        prev_we = (cur_q != NIL);
        prev_wa = cur_q;
        prev_wd = n_q;
      end
      mqsi_pkg::OP_UNL_A: begin
        next_we = (rv_q != NIL);
        next_wa = rv_q;
        next_wd = rn_q;
        prev_we = (rn_q != NIL);
        prev_wa = rn_q;
        prev_wd = rv_q;
      end
      mqsi_pkg::OP_UNL_B: begin
        next_we = 1'b1;
        next_wd = free_head_q;
      end
      default: begin
      end
    endcase
  end

  // Entry memories.
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.op == mqsi_pkg::OP_POP_A) begin
      mem_key[free_head_q[AW-1:0]] <= key_q;
      mem_pay[free_head_q[AW-1:0]] <= pay_q;
    end
    if (next_we) begin
      mem_next[next_wa[AW-1:0]] <= next_wd;
    end
    if (prev_we) begin
      mem_prev[prev_wa[AW-1:0]] <= prev_wd;
    end
    if (rd_en) begin
      rk_q <= mem_key[rd_a];
      rp_q <= mem_pay[rd_a];
      rn_q <= mem_next[rd_a];
      rv_q <= mem_prev[rd_a];
    end
  end

  // Queue tables and free lists. Entries below fresh_q were never handed
  // out and chain downward implicitly, so they need no link storage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUEUES; i++) begin
        head_q[i]  <= NIL;
        tail_q[i]  <= NIL;
        order_q[i] <= '0;
      end
      in_use_q    <= '0;
      qcnt_q      <= QCW'(QUEUES);
      free_head_q <= PW'(NODES - 1);
      fresh_q     <= PW'(NODES);
    end else begin
      case (dp_cmd_i.op)
        mqsi_pkg::OP_ALLOC: begin
          qcnt_q              <= alloc_num;
          head_q[alloc_idx]   <= NIL;
          tail_q[alloc_idx]   <= NIL;
          order_q[alloc_idx]  <= mode_q;
          in_use_q[alloc_idx] <= 1'b1;
        end
        mqsi_pkg::OP_POP_B: begin
          if (n_q < fresh_q) begin
            free_head_q <= (n_q == '0) ? NIL : (n_q - PW'(1));
            fresh_q     <= n_q;
          end else begin
            free_head_q <= rn_q;
          end
        end
        mqsi_pkg::OP_INS_B: begin
          if (p_q == NIL) begin
            head_q[q_idx] <= n_q;
          end
          if (cur_q == NIL) begin
            tail_q[q_idx] <= n_q;
          end
        end
        mqsi_pkg::OP_UNL_A: begin
          if (rv_q == NIL) begin
            head_q[q_idx] <= rn_q;
          end
          if (rn_q == NIL) begin
            tail_q[q_idx] <= rv_q;
          end
        end
        mqsi_pkg::OP_UNL_B: begin
          free_head_q <= n_q;
        end
        default: begin
        end
      endcase
    end
  end

  // Command fields, walk pointers and results.
  always_ff @(posedge clk_i) begin
    case (dp_cmd_i.op)
      mqsi_pkg::OP_LOAD: begin
        cmd_q  <= command_i;
        qid_q  <= queue_id_i;
        mode_q <= order_mode_i;
        key_q  <= key_i;
        pay_q  <= payload_i;
        st_q   <= mqsi_pkg::ST_OK;
        qout_q <= '0;
        kout_q <= '0;
        pout_q <= '0;
      end
      mqsi_pkg::OP_SET_ST:   st_q   <= dp_cmd_i.st;
      mqsi_pkg::OP_ALLOC:    qout_q <= mqsi_pkg::QID_W'(alloc_num);
      mqsi_pkg::OP_POP_A:    n_q    <= free_head_q;
      mqsi_pkg::OP_POP_B:    cur_q  <= head_q[q_idx];
      mqsi_pkg::OP_CUR_HEAD: cur_q  <= head_q[q_idx];
      mqsi_pkg::OP_SET_TAIL: begin
        p_q   <= tail_q[q_idx];
        cur_q <= NIL;
      end
      mqsi_pkg::OP_ADVANCE:  cur_q  <= rn_q;
      mqsi_pkg::OP_SET_PREV: p_q    <= rv_q;
      mqsi_pkg::OP_TAKE_KEY: kout_q <= rk_q;
      mqsi_pkg::OP_TAKE_PAY: begin
        pout_q <= rp_q;
        n_q    <= cur_q;
      end
      default: begin
      end
    endcase
  end

  assign status_o      = st_q;
  assign queue_out_o   = qout_q;
  assign key_out_o     = kout_q;
  assign payload_out_o = pout_q;

endmodule

/* rtl/mqsi_ctrl.sv */
`include "multi_queue_sorted_insert_engine_macros.svh"

module mqsi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mqsi_pkg::dp_cmd_t dp_cmd_o,
  input  mqsi_pkg::dp_sts_t dp_sts_i
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_DEC  = 11'b00000000010,
    S_POPB = 11'b00000000100,
    S_TAIL = 11'b00000001000,
    S_WALK = 11'b00000010000,
    S_CHK  = 11'b00000100000,
    S_INSA = 11'b00001000000,
    S_INSB = 11'b00010000000,
    S_UNLA = 11'b00100000000,
    S_UNLB = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // Sequencing of one transaction.
  always_comb begin
    state_d     = state_q;
    dp_cmd_o.op = mqsi_pkg::OP_IDLE;
    dp_cmd_o.st = mqsi_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          dp_cmd_o.op = mqsi_pkg::OP_LOAD;
          state_d     = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_OUT;
        if (dp_sts_i.cmd == mqsi_pkg::CMD_ALLOC) begin
          if (dp_sts_i.no_queue) begin
            dp_cmd_o.op = mqsi_pkg::OP_SET_ST;
            dp_cmd_o.st = mqsi_pkg::ST_NO_QUEUES;
          end else begin
            dp_cmd_o.op = mqsi_pkg::OP_ALLOC;
          end
        end else if (dp_sts_i.bad) begin
          dp_cmd_o.op = mqsi_pkg::OP_SET_ST;
          dp_cmd_o.st = mqsi_pkg::ST_BAD_QUEUE;
        end else if (dp_sts_i.cmd == mqsi_pkg::CMD_STATUS) begin
          dp_cmd_o.op = mqsi_pkg::OP_SET_ST;
          dp_cmd_o.st = dp_sts_i.q_empty ? mqsi_pkg::ST_EMPTY : mqsi_pkg::ST_NOT_EMPTY;
        end else if (dp_sts_i.cmd == mqsi_pkg::CMD_INSERT) begin
          if (dp_sts_i.pool_empty) begin
            dp_cmd_o.op = mqsi_pkg::OP_SET_ST;
            dp_cmd_o.st = mqsi_pkg::ST_POOL_FULL;
          end else begin
            dp_cmd_o.op = mqsi_pkg::OP_POP_A;
            state_d     = S_POPB;
          end
        end else if (dp_sts_i.q_empty) begin
          dp_cmd_o.op = mqsi_pkg::OP_SET_ST;
          dp_cmd_o.st = mqsi_pkg::ST_EMPTY;
        end else begin
          dp_cmd_o.op = mqsi_pkg::OP_CUR_HEAD;
          state_d     = S_WALK;
        end
      end
      S_POPB: begin
        dp_cmd_o.op = mqsi_pkg::OP_POP_B;
        state_d     = dp_sts_i.sorted ? S_WALK : S_TAIL;
      end
      S_TAIL: begin
        dp_cmd_o.op = mqsi_pkg::OP_SET_TAIL;
        state_d     = S_INSA;
      end
      S_WALK: begin
        if (!dp_sts_i.cur_nil) begin
          dp_cmd_o.op = mqsi_pkg::OP_READ;
          state_d     = S_CHK;
        end else if (dp_sts_i.cmd == mqsi_pkg::CMD_INSERT) begin
          state_d = S_TAIL;
        end else begin
          dp_cmd_o.op = mqsi_pkg::OP_SET_ST;
          dp_cmd_o.st = mqsi_pkg::ST_NOT_FOUND;
          state_d     = S_OUT;
        end
      end
      S_CHK: begin
        if (dp_sts_i.cmd == mqsi_pkg::CMD_INSERT) begin
          if (dp_sts_i.after) begin
            dp_cmd_o.op = mqsi_pkg::OP_SET_PREV;
            state_d     = S_INSA;
          end else begin
            dp_cmd_o.op = mqsi_pkg::OP_ADVANCE;
            state_d     = S_WALK;
          end
        end else if (dp_sts_i.cmd == mqsi_pkg::CMD_PEEK) begin
          dp_cmd_o.op = mqsi_pkg::OP_TAKE_KEY;
          state_d     = S_OUT;
        end else if (dp_sts_i.cmd == mqsi_pkg::CMD_REM_HEAD || dp_sts_i.key_eq) begin
          dp_cmd_o.op = mqsi_pkg::OP_TAKE_PAY;
          state_d     = S_UNLA;
        end else begin
          dp_cmd_o.op = mqsi_pkg::OP_ADVANCE;
          state_d     = S_WALK;
        end
      end
      S_INSA: begin
        dp_cmd_o.op = mqsi_pkg::OP_INS_A;
        state_d     = S_INSB;
      end
      S_INSB: begin
        dp_cmd_o.op = mqsi_pkg::OP_INS_B;
        state_d     = S_OUT;
      end
      S_UNLA: begin
        dp_cmd_o.op = mqsi_pkg::OP_UNL_A;
        state_d     = S_UNLB;
      end
      S_UNLB: begin
        dp_cmd_o.op = mqsi_pkg::OP_UNL_B;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  // Checks on the sequencing.
  `MQSI_ASSERT(a_accept_decodes, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == S_DEC))
  `MQSI_ASSERT(a_result_frees, clk_i, rst_ni, (out_valid_o && out_ready_i) |=> in_ready_o)
  `MQSI_ASSERT_NEVER(a_alloc_full, clk_i, rst_ni, (dp_cmd_o.op == mqsi_pkg::OP_ALLOC) && dp_sts_i.no_queue)
  `MQSI_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, (dp_cmd_o.op == mqsi_pkg::OP_POP_A) && dp_sts_i.pool_empty)

endmodule

/* rtl/multi_queue_sorted_insert_engine.sv */
// Alloc, status and rejected commands go from decode straight to the result; peek and remove
// head read the head entry; remove by key and insert into a sorted queue walk the entries.
// One command is handled at a time; the walk over the linked entries (one entry memory read
// port) sets the worst case per command.
// Reset (rst_ni, asynchronous, active low) clears queue tables, free queue count and free list
// head at once; entry key, payload and link storage are not cleared.
module multi_queue_sorted_insert_engine #(
  parameter int unsigned NODES     = mqsi_pkg::NODES_DEF,
  parameter int unsigned QUEUES    = mqsi_pkg::QUEUES_DEF,
  parameter int unsigned KEY_BITS  = mqsi_pkg::KEY_BITS_DEF,
  parameter int unsigned DATA_BITS = mqsi_pkg::DATA_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [mqsi_pkg::CMD_W-1:0]  command_i,
  input  logic [mqsi_pkg::QID_W-1:0]  queue_id_i,
  input  logic [mqsi_pkg::MODE_W-1:0] order_mode_i,
  input  logic [KEY_BITS-1:0]         key_i,
  input  logic [DATA_BITS-1:0]        payload_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mqsi_pkg::ST_W-1:0]   status_o,
  output logic [mqsi_pkg::QID_W-1:0]  queue_out_o,
  output logic [KEY_BITS-1:0]         key_out_o,
  output logic [DATA_BITS-1:0]        payload_out_o
);

  mqsi_pkg::dp_cmd_t dp_cmd;
  mqsi_pkg::dp_sts_t dp_sts;

  // Controller.
  mqsi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_cmd_o    (dp_cmd),
    .dp_sts_i    (dp_sts)
  );

  // Datapath with queue tables and entry storage.
  mqsi_dp #(
    .NODES     (NODES),
    .QUEUES    (QUEUES),
    .KEY_BITS  (KEY_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .command_i     (command_i),
    .queue_id_i    (queue_id_i),
    .order_mode_i  (order_mode_i),
    .key_i         (key_i),
    .payload_i     (payload_i),
    .dp_cmd_i      (dp_cmd),
    .dp_sts_o      (dp_sts),
    .status_o      (status_o),
    .queue_out_o   (queue_out_o),
    .key_out_o     (key_out_o),
    .payload_out_o (payload_out_o)
  );

endmodule
